// ===== hdl/bde_pkg.sv =====
// Package for the block dictionary encoder: payload structs, sizes, register indexes.
// No dependencies.
package bde_pkg;

   localparam int MaxBlockBytes = 16;
   localparam int DictEntries   = 255;
   localparam int MaxDev        = 8;
   localparam int PosBits       = 5;
   localparam int BlkW          = $clog2(MaxBlockBytes + 1);
   localparam int IdxW          = $clog2(MaxBlockBytes);
   localparam int IdW           = 8;
   localparam int DictDepth     = DictEntries * MaxBlockBytes;
   localparam int DictAw        = $clog2(DictDepth);

   localparam logic [1:0] CSR_BLK_SIZE  = 2'd0;
   localparam logic [1:0] CSR_DEV_COUNT = 2'd1;
   localparam logic [1:0] CSR_DEV_POS   = 2'd2;

   localparam logic [4:0]  RST_BLK_SIZE  = 5'd16;
   localparam logic [3:0]  RST_DEV_COUNT = 4'd4;
   localparam logic [39:0] RST_DEV_POS   = 40'd436420;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic        record_kind;
      logic [7:0]  block_id;
      logic        new_base;
      logic        segment_restart;
      logic [63:0] deviation;
      logic [7:0]  base_byte;
      logic        config_error;
      logic        last;
   } rsp_type;

endpackage

// ===== hdl/bde_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
module bde_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

// ===== hdl/block_dedup_encoder.sv =====
// Block dictionary encoder top level: assembly, deviation extraction, search, output.
// Depends on bde_pkg and bde_ram.
//
// channel | ports              | direction | payload
// req     | req_valid/ready    | in        | req_type (data_byte, stream_end)
// rsp     | rsp_valid/ready    | out       | rsp_type (block record, base bytes)
// csr     | csr_we/index/wdata | in        | block size, deviation count, position list
//
// A byte that does not close a block is only stored. A closing byte runs the
// position check (an out-of-range position emits a config error record) and the
// extraction, then a byte-serial compare through the single dictionary RAM port
// against the filled entries (up to 255 of 16 bytes each). A hit emits its record;
// a miss emits the record and the base bytes while storing the base, then zeroes
// the rest of the entry. Stalls on rsp hold the sequencer. Reset is synchronous.
module block_dedup_encoder
   import bde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [39:0] csr_wdata
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_CHECK  = 11'b00000000010,
      S_EXTR   = 11'b00000000100,
      S_CMPRD  = 11'b00000001000,
      S_CMP    = 11'b00000010000,
      S_REC    = 11'b00000100000,
      S_WRITE  = 11'b00001000000,
      S_BASE   = 11'b00010000000,
      S_WAIT   = 11'b00100000000,
      S_ERR    = 11'b01000000000,
      S_PAD    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0]  blk_ff;
   logic [3:0]  devc_ff;
   logic [39:0] pos_ff;
   logic [7:0]  buf_ff [MaxBlockBytes];
   logic [BlkW-1:0] cnt_ff;
   logic [IdW-1:0]  fill_ff, fill_in;
   logic [IdW-1:0]  ent_ff, ent_in;
   logic [BlkW-1:0] bi_ff, bi_in;
   logic [3:0]  di_ff, di_in;
   logic [63:0] dev_ff, dev_in;
   logic        match_ff, match_in;
   logic        found_ff, found_in;
   logic        rst_ff, rst_in;
   logic        end_ff, end_in;
   logic        ov_ff;
   rsp_type     out_ff;

   logic [BlkW-1:0] bb;
   logic [3:0]      dc;
   logic [PosBits-1:0] cur_pos;
   logic            ram_we;
   logic [DictAw-1:0] ram_addr;
   logic [7:0]      ram_wd;
   logic [7:0]      ram_rd;
   logic            out_free;
   logic            push;
   rsp_type         push_data;
   logic            accept;
   logic            closes;
   logic [BlkW-1:0] widx;

   always_comb begin
      bb = (blk_ff == 5'd0) ? BlkW'(1)
         : ((32'(blk_ff) > MaxBlockBytes) ? BlkW'(MaxBlockBytes) : BlkW'(blk_ff));
      dc = (32'(devc_ff) > MaxDev) ? 4'(MaxDev) : devc_ff;
      cur_pos = pos_ff[di_ff[2:0]*PosBits +: PosBits];
   end

   assign out_free  = !ov_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign widx      = (cnt_ff >= bb) ? bb - BlkW'(1) : cnt_ff;
   assign closes    = (widx + BlkW'(1)) >= bb;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff  <= RST_BLK_SIZE;
         devc_ff <= RST_DEV_COUNT;
         pos_ff  <= RST_DEV_POS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLK_SIZE:  blk_ff  <= csr_wdata[4:0];
            CSR_DEV_COUNT: devc_ff <= csr_wdata[3:0];
            CSR_DEV_POS:   pos_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // RAM address: entry * MaxBlockBytes + byte index
   assign ram_addr = DictAw'(32'(ent_ff) * MaxBlockBytes + 32'(bi_ff[IdxW-1:0]));
   assign ram_we   = (state_ff == S_WRITE) || (state_ff == S_PAD);
   // bytes past the block size are stored as zero
   assign ram_wd   = (state_ff == S_PAD) ? 8'd0 : buf_ff[bi_ff[IdxW-1:0]];

   bde_ram #(.Width(8), .Depth(DictDepth)) u_dict (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wd),
      .rdata (ram_rd)
   );

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      ent_in   = ent_ff;
      bi_in    = bi_ff;
      di_in    = di_ff;
      dev_in   = dev_ff;
      match_in = match_ff;
      found_in = found_ff;
      rst_in   = rst_ff;
      end_in   = end_ff;
      push     = 1'b0;
      push_data = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               end_in = req_data.stream_end;
               if (closes) begin
                  di_in    = '0;
                  state_in = S_CHECK;
               end else if (req_data.stream_end) begin
                  fill_in = '0;
               end
            end
         end
         S_CHECK: begin
            if (di_ff >= dc) begin
               di_in    = '0;
               dev_in   = '0;
               state_in = S_EXTR;
            end else if (BlkW'(cur_pos) >= bb) begin
               state_in = S_ERR;
            end else begin
               di_in = di_ff + 4'd1;
            end
         end
         S_ERR: begin
            if (out_free) begin
               push = 1'b1;
               push_data.config_error = 1'b1;
               push_data.last = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_EXTR: begin
            if (di_ff >= dc) begin
               ent_in   = '0;
               bi_in    = '0;
               found_in = 1'b0;
               match_in = 1'b1;
               state_in = (fill_ff == '0) ? S_REC : S_CMPRD;
            end else begin
               dev_in[di_ff[2:0]*8 +: 8] = buf_ff[cur_pos[IdxW-1:0]];
               di_in = di_ff + 4'd1;
            end
         end
         S_CMPRD: begin
            // address set; read data lands next cycle
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ram_rd != buf_ff[bi_ff[IdxW-1:0]]) begin
               match_in = 1'b0;
            end
            if (bi_ff + BlkW'(1) >= bb) begin
               if (match_in) begin
                  found_in = 1'b1;
                  state_in = S_REC;
               end else if (ent_ff + IdW'(1) >= fill_ff) begin
                  state_in = S_REC;
               end else begin
                  ent_in   = ent_ff + IdW'(1);
                  bi_in    = '0;
                  match_in = 1'b1;
                  state_in = S_CMPRD;
               end
            end else begin
               bi_in    = bi_ff + BlkW'(1);
               state_in = S_CMPRD;
            end
         end
         S_REC: begin
            if (found_ff) begin
               rst_in = 1'b0;
            end else begin
               rst_in = (32'(fill_ff) >= DictEntries);
               ent_in = rst_in ? '0 : fill_ff;
               fill_in = ent_in + IdW'(1);
            end
            if (out_free) begin
               push = 1'b1;
               push_data.block_id        = ent_in;
               push_data.new_base        = !found_ff;
               push_data.segment_restart = rst_in;
               push_data.deviation       = dev_ff;
               push_data.last            = found_ff;
               bi_in    = '0;
               state_in = found_ff ? S_WAIT : S_WRITE;
            end else begin
               fill_in = fill_ff;
               ent_in  = ent_ff;
               rst_in  = rst_ff;
            end
         end
         S_WRITE: begin
            state_in = S_BASE;
         end
         S_BASE: begin
            if (out_free) begin
               push = 1'b1;
               push_data.record_kind     = 1'b1;
               push_data.block_id        = ent_ff;
               push_data.new_base        = 1'b1;
               push_data.segment_restart = rst_ff;
               push_data.base_byte       = buf_ff[bi_ff[IdxW-1:0]];
               push_data.last            = (bi_ff + BlkW'(1) >= bb);
               bi_in    = bi_ff + BlkW'(1);
               if (!push_data.last) begin
                  state_in = S_WRITE;
               end else if (32'(bi_ff) + 1 >= MaxBlockBytes) begin
                  state_in = S_WAIT;
               end else begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            bi_in    = bi_ff + BlkW'(1);
            state_in = (32'(bi_ff) + 1 >= MaxBlockBytes) ? S_WAIT : S_PAD;
         end
         S_WAIT: begin
            if (end_ff) begin
               fill_in = '0;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         fill_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (accept) begin
            cnt_ff <= (closes || req_data.stream_end) ? '0 : widx + BlkW'(1);
         end
         if (push) begin
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      bi_ff    <= bi_in;
      di_ff    <= di_in;
      dev_ff   <= dev_in;
      match_ff <= match_in;
      found_ff <= found_in;
      rst_ff   <= rst_in;
      end_ff   <= end_in;
      if (push) begin
         out_ff <= push_data;
      end
      if (accept) begin
         buf_ff[widx[IdxW-1:0]] <= req_data.data_byte;
      end
      if (state_ff == S_EXTR && di_ff < dc) begin
         buf_ff[cur_pos[IdxW-1:0]] <= 8'd0;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("input taken while busy");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= DictEntries)
      else $error("dictionary fill overflow");
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("output overwritten");
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.config_error) |-> push_data.last)
      else $error("error record not last");
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for block_dedup_encoder: directed and random byte streams.
// Depends on bde_pkg and the encoder RTL; the expected records come from an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;
   import bde_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int DRAIN_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_BLK_SIZE;
   logic [39:0] csr_wdata = '0;

   block_dedup_encoder u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type     byte_q[$];
   rsp_type     record_q[$];
   int          errors = 0;
   int          cycles = 0;
   bit          hold_sender = 1'b0;
   bit          calm = 1'b0;

   // encoder shadow state
   logic [4:0]  sh_blk_size = RST_BLK_SIZE;
   logic [3:0]  sh_dev_count = RST_DEV_COUNT;
   logic [39:0] sh_dev_pos = RST_DEV_POS;
   logic [7:0]  blk_buf[MaxBlockBytes];
   logic [7:0]  dict[DictEntries][MaxBlockBytes];
   int          blk_count = 0;
   int          dict_fill = 0;

   function automatic rsp_type mk_record(logic kind, logic [7:0] id, logic nb, logic rs,
                                         logic [63:0] dev, logic [7:0] bb, logic err,
                                         logic lst);
      rsp_type r;
      r.record_kind = kind; r.block_id = id; r.new_base = nb; r.segment_restart = rs;
      r.deviation = dev; r.base_byte = bb; r.config_error = err; r.last = lst;
      return r;
   endfunction

   task automatic close_block(int bb);
      int          dc;
      int          p;
      int          id;
      bit          found;
      bit          restart;
      bit          bad;
      bit          same;
      logic [63:0] dev;
      dc = (sh_dev_count > MaxDev) ? MaxDev : int'(sh_dev_count);
      bad = 1'b0;
      for (int i = 0; i < dc; i++)
         if (int'(sh_dev_pos[5*i +: 5]) >= bb) bad = 1'b1;
      if (bad) begin
         record_q.push_back(mk_record(1'b0, 8'd0, 1'b0, 1'b0, 64'd0, 8'd0, 1'b1, 1'b1));
         return;
      end
      dev = '0;
      for (int i = 0; i < dc; i++) begin
         p = int'(sh_dev_pos[5*i +: 5]);
         dev[8*i +: 8] = blk_buf[p];
         blk_buf[p] = 8'h00;
      end
      found = 1'b0; restart = 1'b0; id = 0;
      for (int e = 0; e < dict_fill && !found; e++) begin
         same = 1'b1;
         for (int k = 0; k < bb; k++)
            if (dict[e][k] !== blk_buf[k]) same = 1'b0;
         if (same) begin
            found = 1'b1; id = e;
         end
      end
      if (!found) begin
         if (dict_fill >= DictEntries) begin
            dict_fill = 0; restart = 1'b1;
         end
         id = dict_fill;
         for (int k = 0; k < MaxBlockBytes; k++) dict[id][k] = (k < bb) ? blk_buf[k] : 8'h00;
         dict_fill++;
      end
      record_q.push_back(mk_record(1'b0, 8'(id), !found, restart, dev, 8'd0, 1'b0, found));
      if (!found)
         for (int k = 0; k < bb; k++)
            record_q.push_back(mk_record(1'b1, 8'(id), 1'b1, restart, 64'd0, blk_buf[k],
                                         1'b0, k + 1 == bb));
   endtask

   task automatic predict_byte(req_type r);
      int bb;
      int idx;
      bb = (sh_blk_size == 0) ? 1 :
           (sh_blk_size > MaxBlockBytes) ? MaxBlockBytes : int'(sh_blk_size);
      idx = (blk_count >= bb) ? bb - 1 : blk_count;
      blk_buf[idx] = r.data_byte;
      if (idx + 1 >= bb) begin
         blk_count = 0;
         close_block(bb);
      end else begin
         blk_count = idx + 1;
      end
      if (r.stream_end) begin
         blk_count = 0; dict_fill = 0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_byte(req_data);
         if (!req_valid || req_ready) begin
            if (byte_q.size() > 0 && !hold_sender && (calm || $urandom_range(99) >= 24)) begin
               req_valid <= 1'b1;
               req_data  <= byte_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (record_q.size() == 0) begin
               $error("unexpected transaction %h", rsp_data);
               errors++;
            end else begin
               want = record_q.pop_front();
               if (rsp_data.record_kind !== want.record_kind) begin
                  $error("record_kind exp %h got %h", want.record_kind, rsp_data.record_kind);
                  errors++;
               end
               if (rsp_data.block_id !== want.block_id) begin
                  $error("block_id exp %h got %h", want.block_id, rsp_data.block_id);
                  errors++;
               end
               if (rsp_data.new_base !== want.new_base) begin
                  $error("new_base exp %h got %h", want.new_base, rsp_data.new_base);
                  errors++;
               end
               if (rsp_data.segment_restart !== want.segment_restart) begin
                  $error("segment_restart exp %h got %h", want.segment_restart,
                         rsp_data.segment_restart);
                  errors++;
               end
               if (rsp_data.deviation !== want.deviation) begin
                  $error("deviation exp %h got %h", want.deviation, rsp_data.deviation);
                  errors++;
               end
               if (rsp_data.base_byte !== want.base_byte) begin
                  $error("base_byte exp %h got %h", want.base_byte, rsp_data.base_byte);
                  errors++;
               end
               if (rsp_data.config_error !== want.config_error) begin
                  $error("config_error exp %h got %h", want.config_error, rsp_data.config_error);
                  errors++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last exp %h got %h", want.last, rsp_data.last);
                  errors++;
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 24);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("** block_dedup_encoder: FAILED **");
         $finish;
      end
   end

   task automatic push_byte(logic [7:0] b, logic e);
      req_type r;
      r.data_byte = b; r.stream_end = e;
      byte_q.push_back(r);
   endtask

   task automatic wait_quiet();
      while (byte_q.size() > 0 || req_valid) @(posedge clock);
      while (record_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, shadowed when the write is driven; only issued while quiet
   task automatic csr_write(logic [1:0] idx, logic [39:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      case (idx)
         CSR_BLK_SIZE:  sh_blk_size = val[4:0];
         CSR_DEV_COUNT: sh_dev_count = val[3:0];
         default:       sh_dev_pos = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [39:0] rand_positions(int bb);
      logic [39:0] v;
      for (int i = 0; i < 8; i++) v[5*i +: 5] = 5'($urandom_range(bb - 1));
      return v;
   endfunction

   initial begin
      int bb;
      int n;
      logic [7:0] alpha[4];
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // default config: one full block with extreme bytes
      for (int i = 0; i < 16; i++) push_byte((i % 2) ? 8'hFF : 8'h00, 1'b0);
      wait_quiet();

      // small block, clamped dev count, repeated positions; send it twice for a hit
      csr_write(CSR_BLK_SIZE, 40'd4);
      csr_write(CSR_DEV_COUNT, 40'd15);
      csr_write(CSR_DEV_POS, {5'd3, 5'd3, 5'd2, 5'd1, 5'd0, 5'd3, 5'd1, 5'd0});
      for (int r = 0; r < 2; r++)
         for (int i = 0; i < 4; i++) push_byte(8'(8'hA0 + i), 1'b0);
      wait_quiet();

      // bad position drops the block
      csr_write(CSR_DEV_POS, 40'hFF_FFFF_FFFF);
      for (int i = 0; i < 4; i++) push_byte(8'h5A, 1'b0);
      wait_quiet();

      // size 0 counts as one, no deviation bytes; then stream end
      csr_write(CSR_DEV_COUNT, 40'd0);
      csr_write(CSR_BLK_SIZE, 40'd0);
      push_byte(8'h11, 1'b0);
      push_byte(8'h11, 1'b1);
      wait_quiet();

      // size above max counts as max; partial block discarded at stream end
      csr_write(CSR_BLK_SIZE, 40'd31);
      for (int i = 0; i < 3; i++) push_byte(8'h33, i == 2);
      wait_quiet();

      // shrink the block size while a block is partly assembled
      csr_write(CSR_BLK_SIZE, 40'd8);
      for (int i = 0; i < 3; i++) push_byte(8'(8'h44 + i), 1'b0);
      wait_quiet();
      csr_write(CSR_BLK_SIZE, 40'd2);
      push_byte(8'h77, 1'b0);
      wait_quiet();

      // one-byte bases with no idling, then a hit and a stream end
      csr_write(CSR_BLK_SIZE, 40'd1);
      calm = 1'b1;
      for (int i = 0; i < 20; i++) push_byte(i[7:0], 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h01, 1'b1);
      wait_quiet();
      calm = 1'b0;

      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         bb = (ph == 0) ? 16 : (ph == 1) ? 1 : $urandom_range(2, 8);
         csr_write(CSR_BLK_SIZE, 40'(bb));
         csr_write(CSR_DEV_COUNT, 40'((ph == 2) ? 8 : $urandom_range(0, 9)));
         csr_write(CSR_DEV_POS, (ph == 5) ? {8{5'd0}} :
                   ($urandom_range(9) == 0) ? 40'({$urandom, $urandom}) : rand_positions(bb));
         for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom);
         n = (ph == 0) ? 16 : 8;
         for (int i = 0; i < n; i++) begin
            push_byte(($urandom_range(2) == 0) ? 8'($urandom) : alpha[$urandom_range(3)],
                      $urandom_range(39) == 0);
            if (ph == 3 && i == 4) begin
               // sender drains, then holds until every record has come back
               while (byte_q.size() > 0 || req_valid) @(posedge clock);
               hold_sender = 1'b1;
               while (record_q.size() > 0) @(posedge clock);
               hold_sender = 1'b0;
            end
         end
         wait_quiet();
      end

      if (errors == 0) begin
         $display("** block_dedup_encoder: PASSED **");
      end else begin
         $display("** block_dedup_encoder: FAILED **");
      end
      $finish;
   end

endmodule
